// ===== rtl/htsc_pkg.sv =====
// Package for the host table with sequence check.
// Holds table geometry, command and status codes, and controller interface structs.
// No dependencies.
`default_nettype none
package htsc_pkg;
  localparam int unsigned TableSize = 256;
  localparam int unsigned SlotW = $clog2(TableSize);
  localparam int unsigned AddrW = SlotW + 1;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [1:0] {
    CmdLookup  = 2'd0,
    CmdEnter   = 2'd1,
    CmdReceive = 2'd2,
    CmdSend    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StInserted = 2'd1,
    StMissing  = 2'd2,
    StFull     = 2'd3
  } status_e;

  localparam logic CfgStride = 1'b0;
  localparam logic CfgIncarnation = 1'b1;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic wr_ins;
    logic wr_seq;
    logic finish;
    logic present;
    status_e status;
  } ctrl_t;

  typedef struct packed {
    logic clearing;
    logic slot_valid;
    logic host_match;
    logic wrapped;
    logic seq_greater;
    cmd_e cmd;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/htsc_ctrl.sv =====
// Controller state machine for the host table with sequence check.
// Sequences probe reads, inserts and result hand-off. Depends on htsc_pkg.
`default_nettype none
module htsc_ctrl import htsc_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  wire   out_busy_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SRead  = 5'b00010,
    SCheck = 5'b00100,
    SSeq   = 5'b01000,
    SDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.status = StFound;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = !stat_i.clearing;
        if (in_valid_i && !stat_i.clearing) begin
          ctrl_o.load = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        ctrl_o.rd = 1'b1;
        state_d = SCheck;
      end
      SCheck: begin
        if (!stat_i.slot_valid) begin
          if (stat_i.cmd == CmdLookup) begin
            ctrl_o.status = StMissing;
          end else begin
            ctrl_o.status = StInserted;
            ctrl_o.wr_ins = 1'b1;
          end
          state_d = (stat_i.cmd == CmdReceive) ? SSeq : SDone;
        end else if (stat_i.host_match) begin
          ctrl_o.status = StFound;
          state_d = (stat_i.cmd == CmdReceive) ? SSeq : SDone;
        end else if (stat_i.wrapped) begin
          ctrl_o.status = StFull;
          state_d = SDone;
        end else begin
          ctrl_o.step = 1'b1;
          state_d = SRead;
        end
        if (state_d != SRead) begin
          ctrl_o.finish = 1'b1;
        end
        if (state_d == SDone) begin
          ctrl_o.present = 1'b1;
        end
      end
      SSeq: begin
        ctrl_o.wr_seq = stat_i.seq_greater;
        ctrl_o.present = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        if (!out_busy_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/htsc_datapath.sv =====
// Datapath for the host table with sequence check: slot memories, probe index,
// send counter and result register. Depends on htsc_pkg.
`default_nettype none
module htsc_datapath import htsc_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire  [CfgDataW-1:0] cfg_data_i,
  input  wire  [1:0]          command_i,
  input  wire                 table_select_i,
  input  wire  [31:0]         host_address_i,
  input  wire  [30:0]         sequence_number_i,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_busy_o,
  output logic [1:0]          status_o,
  output logic [7:0]          slot_index_o,
  output logic                new_event_o,
  output logic [30:0]         assigned_sequence_o,
  output logic [30:0]         assigned_incarnation_o
);
  localparam int unsigned Depth = 2 * TableSize;

  logic [7:0]       stride_q;
  logic [30:0]      incarnation_q;
  logic [30:0]      counter_q;
  logic             vld_mem [Depth];
  logic [31:0]      host_mem [Depth];
  logic [30:0]      seq_mem [Depth];
  logic [AddrW-1:0] clr_q;
  logic             clearing_q;
  logic [31:0]      rd_host_q;
  logic [30:0]      rd_seq_q;
  logic             rd_valid_q;
  cmd_e             cmd_q;
  logic             tbl_q;
  logic [31:0]      host_q;
  logic [30:0]      seq_q;
  logic [SlotW-1:0] idx_q, start_q, idx_nx;
  logic [AddrW-1:0] addr;
  logic             valid_o_q;
  logic [1:0]       status_q;
  logic [7:0]       slot_q;
  logic             newev_q;
  logic [30:0]      aseq_q, ainc_q;
  logic [SlotW-1:0] step_w;

  assign addr = {tbl_q, idx_q};
  assign step_w = SlotW'(stride_q);
  assign idx_nx = idx_q + step_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q      <= 8'd1;
      incarnation_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgStride) stride_q <= cfg_data_i[7:0];
      else incarnation_q <= cfg_data_i;
    end
  end

  // After reset every slot of both tables is marked empty, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_q <= clr_q + AddrW'(1);
      if (clr_q == AddrW'(Depth - 1)) clearing_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_e'(command_i);
      tbl_q   <= (command_i == CmdReceive) ? 1'b1 :
                 (command_i == CmdSend) ? 1'b0 : table_select_i;
      host_q  <= host_address_i;
      seq_q   <= sequence_number_i;
      idx_q   <= SlotW'(host_address_i[7:0]);
      start_q <= SlotW'(host_address_i[7:0]);
    end else if (ctrl_i.step) begin
      idx_q <= idx_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) rd_valid_q <= vld_mem[addr];
    if (clearing_q) vld_mem[clr_q] <= 1'b0;
    else if (ctrl_i.wr_ins) vld_mem[addr] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_host_q <= host_mem[addr];
      rd_seq_q  <= seq_mem[addr];
    end
    if (ctrl_i.wr_ins) begin
      host_mem[addr] <= host_q;
      seq_mem[addr]  <= '0;
      rd_seq_q       <= '0;
    end else if (ctrl_i.wr_seq) begin
      seq_mem[addr] <= seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q  <= '0;
      valid_o_q  <= 1'b0;
    end else begin
      if (ctrl_i.finish && cmd_q == CmdSend && ctrl_i.status != StFull) begin
        counter_q <= counter_q + 31'd1;
      end
      if (ctrl_i.present) valid_o_q <= 1'b1;
      else if (valid_o_q && out_ready_i) valid_o_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      status_q <= ctrl_i.status;
      slot_q   <= (ctrl_i.status == StFound || ctrl_i.status == StInserted) ?
                  idx_q[7:0] : 8'd0;
      newev_q  <= 1'b0;
      aseq_q   <= '0;
      ainc_q   <= '0;
      if (cmd_q == CmdSend && ctrl_i.status != StFull) begin
        aseq_q <= counter_q + 31'd1;
        ainc_q <= incarnation_q;
      end
    end else if (ctrl_i.wr_seq) begin
      newev_q <= 1'b1;
    end
  end

  assign stat_o.clearing    = clearing_q;
  assign stat_o.slot_valid  = rd_valid_q;
  assign stat_o.host_match  = (rd_host_q == host_q);
  assign stat_o.wrapped     = (idx_nx == start_q);
  assign stat_o.seq_greater = (seq_q > rd_seq_q);
  assign stat_o.cmd         = cmd_q;

  assign out_busy_o             = valid_o_q;
  assign out_valid_o            = valid_o_q;
  assign status_o               = status_q;
  assign slot_index_o           = slot_q;
  assign new_event_o            = newev_q;
  assign assigned_sequence_o    = aseq_q;
  assign assigned_incarnation_o = ainc_q;
endmodule
`default_nettype wire

// ===== rtl/host_table_with_sequence_check_core.sv =====
// Each item is loaded, then every probed slot is read and checked in turn
// (SRead, SCheck); a receive adds a sequence-update step (SSeq) before the
// registered result becomes valid.
// A new item is accepted once the previous result is transferred.
// Reset starts a clearing pass that empties both tables with the input
// held off; it clears the send counter, sets the stride to 1 and incarnation to 0.
// Top level: joins htsc_ctrl and htsc_datapath; depends on htsc_pkg.
`default_nettype none
module host_table_with_sequence_check_core import htsc_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire  [CfgDataW-1:0] cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [1:0]          command_i,
  input  wire                 table_select_i,
  input  wire  [31:0]         host_address_i,
  input  wire  [30:0]         sequence_number_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [1:0]          status_o,
  output logic [7:0]          slot_index_o,
  output logic                new_event_o,
  output logic [30:0]         assigned_sequence_o,
  output logic [30:0]         assigned_incarnation_o
);
  ctrl_t ctrl;
  stat_t stat;
  logic  busy;

  htsc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(busy), .stat_i(stat), .ctrl_o(ctrl)
  );

  htsc_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .command_i, .table_select_i, .host_address_i, .sequence_number_i,
    .ctrl_i(ctrl), .stat_o(stat), .out_valid_o, .out_ready_i,
    .out_busy_o(busy), .status_o, .slot_index_o, .new_event_o,
    .assigned_sequence_o, .assigned_incarnation_o
  );

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input accepted with result pending");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.wr_ins && ctrl.wr_seq)) else $error("two table writes at once");
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StFull) |-> slot_index_o == 8'd0)
    else $error("slot index on full table");
`endif
endmodule
`default_nettype wire
